>>> rtl/fsif_pkg.sv
// Shared types, constants and a helper function of the integer text formatter.
package fsif_pkg;

    localparam int OUT_LIMIT_DEF = 63;
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam logic [5:0] MAX_RESULTS = 6'd63;
    localparam int NUM_DIGITS = 11;

    localparam logic [1:0] CMD_FMT = 2'd0;
    localparam logic [1:0] CMD_STR = 2'd1;
    localparam logic [1:0] CMD_END = 2'd2;

    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UPA   = 8'h41;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_UPX   = 8'h58;
    localparam logic [7:0] CH_C     = 8'h63;

    localparam logic [31:0] RECIP10 = 32'hcccccccd;

    typedef enum logic [1:0] {
        OP_CHAR = 2'd0,
        OP_NUM  = 2'd1,
        OP_END  = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  ch;
        logic [31:0] arg;
        logic        zero_pad;
        logic [7:0]  width;
        logic        hex;
        logic        sgn;
    } t_op;

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] c;
        if (d < 4'd10) begin
            c = CH_ZERO + {4'd0, d};
        end else begin
            c = CH_UPA + {4'd0, d} - 8'd10;
        end
        return c;
    endfunction

endpackage

>>> rtl/fsif_front.sv
// Format parser: accepts requests, tracks the conversion spec, issues operations.
module fsif_front import fsif_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_take,
    input  logic [1:0]  i_cmd,
    input  logic [7:0]  i_in_char,
    input  logic [31:0] i_arg_value,
    output logic        o_push,
    output t_op         o_op
);

    typedef enum logic [2:0] {
        PH_LITERAL = 3'b001,
        PH_FLAG    = 3'b010,
        PH_WIDTH   = 3'b100
    } t_phase;

    t_phase     r_phase, n_phase;
    logic       r_zp, n_zp;
    logic [7:0] r_w, n_w;

    always_comb begin
        n_phase = r_phase;
        n_zp = r_zp;
        n_w = r_w;
        o_push = 1'b0;
        o_op.kind = OP_CHAR;
        o_op.ch = i_in_char;
        o_op.arg = i_arg_value;
        o_op.zero_pad = r_zp;
        o_op.width = r_w;
        o_op.hex = 1'b0;
        o_op.sgn = 1'b0;
        if (i_take) begin
            if (i_cmd == CMD_END) begin
                o_push = 1'b1;
                o_op.kind = OP_END;
                n_phase = PH_LITERAL;
                n_zp = 1'b0;
                n_w = 8'd0;
            end else if (i_cmd == CMD_STR) begin
                o_push = (i_in_char != 8'd0);
            end else if (i_cmd == CMD_FMT) begin
                if (r_phase == PH_LITERAL) begin
                    if (i_in_char == CH_PCT) begin
                        n_phase = PH_FLAG;
                        n_zp = 1'b0;
                        n_w = 8'd0;
                    end else begin
                        o_push = (i_in_char != 8'd0);
                    end
                end else if (r_phase == PH_FLAG && i_in_char == CH_ZERO) begin
                    n_zp = 1'b1;
                    n_phase = PH_WIDTH;
                end else if (i_in_char >= CH_ZERO && i_in_char <= CH_NINE) begin
                    n_w = {r_w[4:0], 3'b000} + {r_w[6:0], 1'b0} + (i_in_char - CH_ZERO);
                    n_phase = PH_WIDTH;
                end else begin
                    n_phase = PH_LITERAL;
                    n_zp = 1'b0;
                    n_w = 8'd0;
                    if (i_in_char == CH_D || i_in_char == CH_I) begin
                        o_push = 1'b1;
                        o_op.kind = OP_NUM;
                        o_op.sgn = 1'b1;
                    end else if (i_in_char == CH_U) begin
                        o_push = 1'b1;
                        o_op.kind = OP_NUM;
                    end else if (i_in_char == CH_X || i_in_char == CH_UPX) begin
                        o_push = 1'b1;
                        o_op.kind = OP_NUM;
                        o_op.hex = 1'b1;
                    end else if (i_in_char == CH_C) begin
                        o_push = 1'b1;
                        o_op.ch = i_arg_value[7:0];
                    end else if (i_in_char == CH_PCT) begin
                        o_push = 1'b1;
                        o_op.ch = CH_PCT;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LITERAL;
            r_zp <= 1'b0;
            r_w <= 8'd0;
        end else begin
            r_phase <= n_phase;
            r_zp <= n_zp;
            r_w <= n_w;
        end
    end

endmodule

>>> rtl/fsif_queue.sv
// Small operation queue between parser and emitter.
module fsif_queue import fsif_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_op,
    output logic o_full,
    input  logic i_pop,
    output logic o_nonempty,
    output t_op  o_op
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_op           r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [AW:0]   r_count;

    assign o_full = (r_count == (AW+1)'(DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_op = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH-1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(DEPTH-1)) ? '0 : r_rd + 1'b1;
            end
            r_count <= r_count + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end

endmodule

>>> rtl/fsif_back.sv
// Emitter: converts numbers, pads, applies the output limit, drives results.
module fsif_back import fsif_pkg::*; #(
    parameter int OUT_LIMIT = OUT_LIMIT_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_nonempty,
    input  t_op        i_op,
    output logic       o_pop,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_char,
    output logic       o_last
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b00000001,
        S_CHAR = 8'b00000010,
        S_END  = 8'b00000100,
        S_HEX  = 8'b00001000,
        S_MUL  = 8'b00010000,
        S_FIX  = 8'b00100000,
        S_PAD  = 8'b01000000,
        S_DIG  = 8'b10000000
    } t_state;

    t_state      r_state, n_state;
    t_op         r_op, n_op;
    logic [31:0] r_mag, n_mag;
    logic [63:0] r_prod;
    logic [3:0]  r_cnt, n_cnt;
    logic        r_neg, n_neg;
    logic        r_sign_due, n_sign_due;
    logic [7:0]  r_w, n_w;
    logic [7:0]  r_cw, n_cw;
    logic [5:0]  r_n, n_n;
    logic [7:0]  r_dig [NUM_DIGITS];
    logic        dig_we;
    logic [7:0]  dig_val;
    logic        r_ovalid, n_ovalid;
    logic [7:0]  r_ochar, n_ochar;
    logic        r_olast, n_olast;

    logic        can_emit, out_free, adv, load;
    logic [7:0]  emit_char;
    logic [31:0] q, rem;
    logic [7:0]  len;

    assign can_emit = (r_cw < 8'(OUT_LIMIT)) && (r_n < MAX_RESULTS);
    assign out_free = !r_ovalid || i_out_ready;
    assign adv = !can_emit || out_free;
    assign q = {3'd0, r_prod[63:35]};
    assign rem = r_mag - ({q[28:0], 3'b000} + {q[30:0], 1'b0});
    assign len = {4'd0, r_cnt} + {7'd0, r_neg};

    always_comb begin
        n_state = r_state;
        n_op = r_op;
        n_mag = r_mag;
        n_cnt = r_cnt;
        n_neg = r_neg;
        n_sign_due = r_sign_due;
        n_w = r_w;
        n_cw = r_cw;
        n_n = r_n;
        o_pop = 1'b0;
        dig_we = 1'b0;
        dig_val = digit_char(r_mag[3:0]);
        load = 1'b0;
        emit_char = r_op.ch;
        n_olast = r_olast;
        unique case (r_state)
            S_IDLE: begin
                if (i_nonempty) begin
                    o_pop = 1'b1;
                    n_op = i_op;
                    n_n = 6'd0;
                    n_cnt = 4'd0;
                    n_w = i_op.width;
                    n_neg = i_op.sgn && i_op.arg[31];
                    n_sign_due = i_op.sgn && i_op.arg[31];
                    n_mag = (i_op.sgn && i_op.arg[31]) ? (32'd0 - i_op.arg) : i_op.arg;
                    unique case (i_op.kind)
                        OP_NUM:  n_state = i_op.hex ? S_HEX : S_MUL;
                        OP_END:  n_state = S_END;
                        default: n_state = S_CHAR;
                    endcase
                end
            end
            S_CHAR: begin
                load = can_emit && out_free;
                if (adv) begin
                    n_state = S_IDLE;
                end
            end
            S_END: begin
                if (out_free) begin
                    n_state = S_IDLE;
                    n_cw = 8'd0;
                end
            end
            S_HEX: begin
                dig_we = 1'b1;
                n_cnt = r_cnt + 4'd1;
                n_mag = {4'd0, r_mag[31:4]};
                if (r_mag[31:4] == 28'd0 || r_cnt == 4'(NUM_DIGITS-1)) begin
                    n_state = S_PAD;
                end
            end
            S_MUL: begin
                n_state = S_FIX;
            end
            S_FIX: begin
                dig_we = 1'b1;
                dig_val = digit_char(rem[3:0]);
                n_cnt = r_cnt + 4'd1;
                n_mag = q;
                n_state = (q == 32'd0 || r_cnt == 4'(NUM_DIGITS-1)) ? S_PAD : S_MUL;
            end
            S_PAD: begin
                if (len < r_w) begin
                    emit_char = r_op.zero_pad ? CH_ZERO : CH_SPACE;
                    load = can_emit && out_free;
                    if (adv) begin
                        n_w = r_w - 8'd1;
                    end
                end else begin
                    n_state = S_DIG;
                end
            end
            S_DIG: begin
                if (r_sign_due) begin
                    emit_char = CH_MINUS;
                    load = can_emit && out_free;
                    if (adv) begin
                        n_sign_due = 1'b0;
                    end
                end else begin
                    emit_char = r_dig[r_cnt - 4'd1];
                    load = can_emit && out_free;
                    if (adv) begin
                        n_cnt = r_cnt - 4'd1;
                        if (r_cnt == 4'd1) begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase

        n_ovalid = r_ovalid && !i_out_ready;
        n_ochar = r_ochar;
        if (r_state == S_END && out_free) begin
            n_ovalid = 1'b1;
            n_ochar = 8'd0;
            n_olast = 1'b1;
        end else if (load) begin
            n_ovalid = 1'b1;
            n_ochar = emit_char;
            n_olast = 1'b0;
            n_cw = r_cw + 8'd1;
            n_n = r_n + 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= r_mag * RECIP10;
        r_op <= n_op;
        r_mag <= n_mag;
        r_cnt <= n_cnt;
        r_neg <= n_neg;
        r_sign_due <= n_sign_due;
        r_w <= n_w;
        r_n <= n_n;
        r_ochar <= n_ochar;
        r_olast <= n_olast;
        if (dig_we) begin
            r_dig[r_cnt] <= dig_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cw <= 8'd0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cw <= n_cw;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_char = r_ochar;
    assign o_last = r_olast;

endmodule

>>> rtl/format_string_integer_formatter.sv
// Top level of the printf-style integer text formatter.
// One request is one format character, string character or end marker; the
// block emits one output character per cycle while it pads or writes digits
// and the sink is ready. The parser takes a request whenever its queue has
// room. The emitter takes an operation from the queue in its idle state and
// then emits its characters. A decimal conversion produces each digit by a
// reciprocal multiply and a correction, and a hex conversion by a shift; the
// pad state then writes the padding and hands over to the digit state. The
// widest field is 255. At most OUT_LIMIT characters are written per string;
// the end marker always yields a zero terminator with o_last set and restarts
// the count.
module format_string_integer_formatter import fsif_pkg::*; #(
    parameter int OUT_LIMIT = OUT_LIMIT_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_cmd,
    input  logic [7:0]  i_in_char,
    input  logic [31:0] i_arg_value,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_char,
    output logic        o_last
);

    logic q_full, q_nonempty, push, pop;
    t_op  push_op, head_op;

    assign o_in_ready = !q_full;

    fsif_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (i_in_valid && !q_full),
        .i_cmd       (i_cmd),
        .i_in_char   (i_in_char),
        .i_arg_value (i_arg_value),
        .o_push      (push),
        .o_op        (push_op)
    );

    fsif_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_op       (push_op),
        .o_full     (q_full),
        .i_pop      (pop),
        .o_nonempty (q_nonempty),
        .o_op       (head_op)
    );

    fsif_back #(.OUT_LIMIT(OUT_LIMIT)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_nonempty  (q_nonempty),
        .i_op        (head_op),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_char  (o_out_char),
        .o_last      (o_last)
    );

endmodule

>>> rtl/fsif_checker.sv
// Port-level checker for the formatter, with its bind to the top level.
module fsif_checker import fsif_pkg::*; #(
    parameter int OUT_LIMIT = OUT_LIMIT_DEF
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [7:0]  o_out_char,
    input logic        o_last
);

    logic [8:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 9'd0;
        end else if (o_out_valid && i_out_ready) begin
            r_count <= o_last ? 9'd0 : r_count + 9'd1;
        end
    end

    a_term_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last |-> o_out_char == 8'd0)
        else $error("terminator carries a nonzero character");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_char) && $stable(o_last))
        else $error("stalled result changed");

    a_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last |-> r_count < 9'(OUT_LIMIT))
        else $error("more characters than the limit before a terminator");

endmodule

bind format_string_integer_formatter fsif_checker #(.OUT_LIMIT(OUT_LIMIT)) u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_char  (o_out_char),
    .o_last      (o_last)
);

>>> dv/tb_format_string_integer_formatter.sv
// Self-checking testbench of the printf-style integer text formatter.
module tb_format_string_integer_formatter;
    import fsif_pkg::*;

    localparam int LIMIT = 63;
    localparam logic [1:0] PH_LIT = 2'd0;
    localparam logic [1:0] PH_FLAG = 2'd1;
    localparam logic [1:0] PH_WID = 2'd2;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_char_out;

    int errors = 0;

    task automatic report(input string msg);
        $display("MISMATCH: %s", msg);
        errors++;
    endtask

    class text_scoreboard;
        logic [1:0] phase;
        logic       zpad;
        logic [7:0] width;
        int         written;
        t_char_out  pending[$];

        function void clear();
            phase = PH_LIT;
            zpad = 1'b0;
            width = 8'd0;
            written = 0;
        endfunction

        function void put(input logic [7:0] c);
            t_char_out r;
            if (written >= LIMIT) return;
            r.ch = c;
            r.last = 1'b0;
            pending.push_back(r);
            written++;
        endfunction

        function void put_number(input logic [31:0] raw, input int radix, input bit sgn);
            logic [7:0] dig[12];
            int cnt;
            int len;
            int w;
            bit neg;
            logic [31:0] mag;
            logic [31:0] d;
            cnt = 0;
            neg = 0;
            mag = raw;
            w = width;
            if (sgn && raw[31]) begin
                neg = 1;
                mag = 32'd0 - raw;
            end
            do begin
                d = mag % radix;
                dig[cnt] = (d < 10) ? (CH_ZERO + d[7:0]) : (CH_UPA + d[7:0] - 8'd10);
                cnt++;
                mag = mag / radix;
            end while (mag != 0 && cnt < 11);
            len = cnt + (neg ? 1 : 0);
            while (len < w) begin
                put(zpad ? CH_ZERO : CH_SPACE);
                w--;
            end
            if (neg) put(CH_MINUS);
            while (cnt > 0) begin
                cnt--;
                put(dig[cnt]);
            end
        endfunction

        function void note_request(input logic [1:0] cmd, input logic [7:0] ch,
                                   input logic [31:0] arg);
            t_char_out r;
            if (cmd == CMD_END) begin
                r.ch = 8'd0;
                r.last = 1'b1;
                pending.push_back(r);
                clear();
                return;
            end
            if (cmd == CMD_STR) begin
                if (ch != 8'd0) put(ch);
                return;
            end
            if (cmd != CMD_FMT) return;
            if (phase == PH_LIT) begin
                if (ch == CH_PCT) begin
                    phase = PH_FLAG;
                    zpad = 1'b0;
                    width = 8'd0;
                end else if (ch != 8'd0) begin
                    put(ch);
                end
                return;
            end
            if (phase == PH_FLAG && ch == CH_ZERO) begin
                zpad = 1'b1;
                phase = PH_WID;
                return;
            end
            if (ch >= CH_ZERO && ch <= CH_NINE) begin
                width = width * 8'd10 + (ch - CH_ZERO);
                phase = PH_WID;
                return;
            end
            case (ch)
                CH_D, CH_I: put_number(arg, 10, 1);
                CH_U: put_number(arg, 10, 0);
                CH_X, CH_UPX: put_number(arg, 16, 0);
                CH_C: put(arg[7:0]);
                CH_PCT: put(CH_PCT);
                default: ;
            endcase
            phase = PH_LIT;
            zpad = 1'b0;
            width = 8'd0;
        endfunction

        task check(input logic [7:0] ch, input logic last);
            t_char_out e;
            if (pending.size() == 0) begin
                report($sformatf("unexpected char %h last %b", ch, last));
                return;
            end
            e = pending.pop_front();
            if (e.ch !== ch) report($sformatf("char %h, want %h", ch, e.ch));
            if (e.last !== last) report($sformatf("last %b, want %b", last, e.last));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_cmd;
    logic [7:0]  i_in_char;
    logic [31:0] i_arg_value;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [7:0]  o_out_char;
    logic        o_last;

    text_scoreboard sb;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    format_string_integer_formatter u_top (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50000000;
        $display("tb_format_string_integer_formatter: done, errors");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check(o_out_char, o_last);
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send(input logic [1:0] cmd, input logic [7:0] ch, input logic [31:0] arg);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd <= cmd;
        i_in_char <= ch;
        i_arg_value <= arg;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_request(cmd, ch, arg);
    endtask

    task automatic fmt(input logic [7:0] ch, input logic [31:0] arg = 32'd0);
        send(CMD_FMT, ch, arg);
    endtask

    function automatic logic [7:0] conv_char();
        logic [7:0] c[8] = '{CH_D, CH_I, CH_U, CH_X, CH_UPX, CH_C, CH_PCT, 8'h73};
        return c[$urandom_range(7)];
    endfunction

    function automatic logic [31:0] rand_arg();
        case ($urandom_range(4))
            0: return 32'd0;
            1: return 32'hffffffff;
            2: return 32'h80000000;
            3: return $urandom_range(999);
            default: return $urandom;
        endcase
    endfunction

    task automatic random_string();
        int n;
        n = $urandom_range(1, 8);
        repeat (n) begin
            case ($urandom_range(9))
                0, 1: fmt(8'($urandom_range(32, 126)));
                2: send(CMD_STR, 8'($urandom), 32'd0);
                3: send(2'($urandom_range(3)), 8'($urandom), $urandom);
                default: begin
                    fmt(CH_PCT);
                    if ($urandom_range(1)) fmt(CH_ZERO);
                    if ($urandom_range(2) != 0) fmt(CH_ZERO + 8'($urandom_range(9)));
                    if ($urandom_range(5) == 0) fmt(CH_ZERO + 8'($urandom_range(9)));
                    if ($urandom_range(9) == 0) fmt(8'($urandom), $urandom);
                    else fmt(conv_char(), rand_arg());
                end
            endcase
        end
        send(CMD_END, 8'($urandom), $urandom);
    endtask

    initial begin
        sb = new();
        sb.clear();
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_cmd = CMD_FMT;
        i_in_char = 8'd0;
        i_arg_value = 32'd0;
        i_out_ready = 1'b1;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        fmt(8'h41);
        fmt(8'h00);
        fmt(8'hff);
        fmt(CH_PCT); fmt(CH_D, 32'h80000000);
        fmt(CH_PCT); fmt(CH_ZERO); fmt(8'h38); fmt(CH_I, 32'hfffffff6);
        fmt(CH_PCT); fmt(8'h31); fmt(8'h32); fmt(CH_U, 32'hffffffff);
        fmt(CH_PCT); fmt(CH_ZERO); fmt(CH_ZERO); fmt(CH_X, 32'h0);
        fmt(CH_PCT); fmt(CH_UPX, 32'hdeadbeef);
        fmt(CH_PCT); fmt(CH_C, 32'h12345678);
        fmt(CH_PCT); fmt(CH_PCT);
        fmt(CH_PCT); fmt(8'h00);
        send(CMD_STR, 8'h00, 32'd0);
        send(CMD_STR, 8'hff, 32'd0);
        send(2'd3, 8'hff, 32'hffffffff);
        send(CMD_END, 8'h00, 32'd0);
        // wide pad from a wrapped width (299 wraps to 43), then a literal
        fmt(CH_PCT); fmt(8'h32); fmt(8'h39); fmt(8'h39); fmt(CH_D, 32'd5);
        fmt(8'h41);
        send(CMD_END, 8'hff, 32'hffffffff);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 80; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 80; end
                default: begin send_idle_pct = 13; recv_stall_pct = 13; end
            endcase
            repeat (4) random_string();
        end
        i_in_valid <= 1'b0;

        for (int t = 0; t < 200000 && sb.pending.size() != 0; t++) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (errors == 0 && sb.pending.size() == 0) begin
            $display("tb_format_string_integer_formatter: done, clean");
        end else begin
            $display("tb_format_string_integer_formatter: done, errors");
        end
        $finish;
    end
endmodule
